### sv/rgbhsv_pkg.sv
// Shared constants and types for the RGB to HSV pixel converter.
// No dependencies; imported by rgbhsv_div, rgb_to_hsv_top and tb_top.
package rgbhsv_pkg;

  // Pixel channel and result widths
  localparam int PixW = 8;
  localparam int HueW = 15;
  localparam int SatW = 16;

  // Divider geometry: dividend, divisor and quotient widths, bits per stage
  localparam int NumW     = 25;
  localparam int DenW     = 9;
  localparam int QuoW     = 16;
  localparam int DivBits  = 2;
  localparam int DivStages = QuoW / DivBits;

  // Hue scale in 1/64 degree units
  localparam logic [HueW-1:0] HUE_SECTOR  = 15'd3840;
  localparam logic [HueW-1:0] HUE_RED_ADD = 15'd19200;
  localparam logic [HueW-1:0] HUE_BLUE_ADD = 15'd11520;
  localparam logic [HueW-1:0] HUE_FULL    = 15'd23040;

  // Hue sector codes
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Per-pixel data that travels alongside the dividers
  typedef struct packed {
    logic [1:0]      sector;
    logic            grey;
    logic [PixW-1:0] mx;
    logic [PixW-1:0] alpha;
  } side_t;

endpackage

### sv/rgbhsv_div.sv
// Pipelined restoring divider, DivBits quotient bits per register stage.
// Depends on rgbhsv_pkg. Requires dividend < divisor * 2**QuoW.
module rgbhsv_div (
  input  logic                        clk,
  input  logic [rgbhsv_pkg::NumW-1:0] dividend,
  input  logic [rgbhsv_pkg::DenW-1:0] divisor,
  output logic [rgbhsv_pkg::QuoW-1:0] quotient
);
  import rgbhsv_pkg::*;

  logic [NumW-1:0] rem_q [DivStages];
  logic [QuoW-1:0] quo_q [DivStages];
  logic [DenW-1:0] den_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [NumW-1:0] rem_in;
    logic [QuoW-1:0] quo_in;
    logic [DenW-1:0] den_in;
    logic [NumW-1:0] rem_next;
    logic [QuoW-1:0] quo_next;

    if (s == 0) begin : g_first
      assign rem_in = dividend;
      assign quo_in = '0;
      assign den_in = divisor;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      logic [NumW-1:0] sh;
      rem_next = rem_in;
      quo_next = quo_in;
      for (int k = 0; k < DivBits; k++) begin
        // trial subtract of the divisor aligned to this quotient bit
        sh = NumW'(den_in) << (QuoW - 1 - (s * DivBits + k));
        if (rem_next >= sh) begin
          rem_next = rem_next - sh;
          quo_next = quo_next | (QuoW'(1) << (QuoW - 1 - (s * DivBits + k)));
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_next;
      quo_q[s] <= quo_next;
      den_q[s] <= den_in;
    end
  end

  assign quotient = quo_q[DivStages-1];

endmodule

### sv/rgb_to_hsv_top.sv
// RGB to HSV pixel converter, top level.
// Depends on rgbhsv_pkg and rgbhsv_div (two instances: hue and saturation).
//
//   channel  ports                                   handshake
//   input    red, green, blue, alpha                 start (taken when busy low)
//   result   hue, saturation, brightness, opacity    done, one cycle per result
//
// One pixel is taken every cycle; busy stays low since nothing downstream stalls.
// Pipeline stages in order: min/max select, dividend build,
// eight divider stages of two quotient bits each, and the hue wrap/output stage.
// Synchronous reset clears the valid chain; payload registers are not reset.
module rgb_to_hsv_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rgbhsv_pkg::PixW-1:0] red,
  input  logic [rgbhsv_pkg::PixW-1:0] green,
  input  logic [rgbhsv_pkg::PixW-1:0] blue,
  input  logic [rgbhsv_pkg::PixW-1:0] alpha,
  output logic                        done,
  output logic [rgbhsv_pkg::HueW-1:0] hue,
  output logic [rgbhsv_pkg::SatW-1:0] saturation,
  output logic [rgbhsv_pkg::PixW-1:0] brightness,
  output logic [rgbhsv_pkg::PixW-1:0] opacity
);
  import rgbhsv_pkg::*;

  // ---------------- stage A: max, min, sector, signed diff
  logic [PixW-1:0] mx_c, mn_c;
  logic [1:0]      sector_c;
  logic signed [PixW:0] diff_c;

  logic            vld_a;
  logic [1:0]      sector_a;
  logic signed [PixW:0] diff_a;
  logic [PixW-1:0] chroma_a, mx_a, alpha_a;

  assign busy = 1'b0;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c)  mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c)  mn_c = blue;
    // red wins ties, then green
    if (mx_c == red) begin
      sector_c = SEC_RED;
      diff_c   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (mx_c == green) begin
      sector_c = SEC_GREEN;
      diff_c   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sector_c = SEC_BLUE;
      diff_c   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= start && !busy;
    end
    sector_a <= sector_c;
    diff_a   <= diff_c;
    chroma_a <= mx_c - mn_c;
    mx_a     <= mx_c;
    alpha_a  <= alpha;
  end

  // ---------------- stage B: dividends for both divisions
  // hue: floor((7680*(diff+chroma) + chroma) / (2*chroma)), then minus 3840 later
  // sat: floor((131070*chroma + max) / (2*max))
  logic [PixW+1:0] dc_wide;
  logic [DenW-1:0] dc;
  logic [NumW-1:0] hue_num_c, sat_num_c;

  logic            vld_b;
  logic [NumW-1:0] hue_num_b, sat_num_b;
  logic [DenW-1:0] hue_den_b, sat_den_b;
  side_t           side_b;

  assign dc_wide   = 10'($unsigned(diff_a)) + 10'(chroma_a);
  assign dc        = dc_wide[DenW-1:0];
  assign hue_num_c = (NumW'(dc) << 13) - (NumW'(dc) << 9) + NumW'(chroma_a);
  assign sat_num_c = (NumW'(chroma_a) << 17) - (NumW'(chroma_a) << 1) + NumW'(mx_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else begin
      vld_b <= vld_a;
    end
    hue_num_b     <= hue_num_c;
    sat_num_b     <= sat_num_c;
    hue_den_b     <= {chroma_a, 1'b0};
    sat_den_b     <= {mx_a, 1'b0};
    side_b.sector <= sector_a;
    side_b.grey   <= (chroma_a == '0);
    side_b.mx     <= mx_a;
    side_b.alpha  <= alpha_a;
  end

  // ---------------- divider stages
  logic [QuoW-1:0] hue_quo, sat_quo;

  rgbhsv_div u_hue_div (
    .clk      (clk),
    .dividend (hue_num_b),
    .divisor  (hue_den_b),
    .quotient (hue_quo)
  );

  rgbhsv_div u_sat_div (
    .clk      (clk),
    .dividend (sat_num_b),
    .divisor  (sat_den_b),
    .quotient (sat_quo)
  );

  // hold sideband and valid in step with the dividers
  logic  vld_q  [DivStages];
  side_t side_q [DivStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DivStages; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= vld_b;
      for (int s = 1; s < DivStages; s++) vld_q[s] <= vld_q[s-1];
    end
    side_q[0] <= side_b;
    for (int s = 1; s < DivStages; s++) side_q[s] <= side_q[s-1];
  end

  // ---------------- output stage: place hue in its sector and wrap
  side_t           side_e;
  logic [HueW-1:0] q_hue;
  logic [HueW-1:0] hue_next;
  logic [SatW-1:0] sat_next;

  assign side_e = side_q[DivStages-1];
  assign q_hue  = hue_quo[HueW-1:0];

  always_comb begin
    case (side_e.sector)
      SEC_RED: begin
        if (q_hue >= HUE_SECTOR) hue_next = q_hue - HUE_SECTOR;
        else                     hue_next = q_hue + HUE_RED_ADD;
      end
      SEC_GREEN: hue_next = q_hue + HUE_SECTOR;
      SEC_BLUE:  hue_next = q_hue + HUE_BLUE_ADD;
      default:   hue_next = '0;
    endcase
    sat_next = sat_quo;
    if (side_e.grey) begin
      hue_next = '0;
      sat_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_q[DivStages-1];
    end
    hue        <= hue_next;
    saturation <= sat_next;
    brightness <= side_e.mx;
    opacity    <= side_e.alpha;
  end

  // ---------------- checks
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue < HUE_FULL))
    else $error("hue out of range");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && (saturation == '0)) |-> (hue == '0))
    else $error("grey pixel with nonzero hue");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && (brightness == '0)) |-> (saturation == '0))
    else $error("black pixel with nonzero saturation");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld_b |-> ##(DivStages + 1) done)
    else $error("pixel lost in pipeline");

endmodule

### sim/tb_top.sv
// Self-checking testbench for rgb_to_hsv_top: random and directed RGBA pixels.
// Depends on rgbhsv_pkg (widths, sector codes) and rgb_to_hsv_top.
`timescale 1ns / 1ps

module tb_top;
  import rgbhsv_pkg::*;

  localparam int HueStep   = 3840;   // 60 degrees in 1/64 degree units
  localparam int HueCircle = 23040;
  localparam int SatScale  = 65535;
  localparam int PerPhase  = 335;
  localparam int TailWait  = 2 * (DivStages + 3);
  localparam int StallLimit = 4000;
  localparam int MaxPrints = 40;

  typedef struct packed {
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
    logic [PixW-1:0] a;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] sat;
    logic [PixW-1:0] val;
    logic [PixW-1:0] opac;
  } hsv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [PixW-1:0] red = '0;
  logic [PixW-1:0] green = '0;
  logic [PixW-1:0] blue = '0;
  logic [PixW-1:0] alpha = '0;
  logic busy;
  logic done;
  logic [HueW-1:0] hue;
  logic [SatW-1:0] saturation;
  logic [PixW-1:0] brightness;
  logic [PixW-1:0] opacity;

  pixel_t pixel_q[$];
  hsv_t   hsv_expected_q[$];
  int     idle_pct = 0;
  int     n_queued = 0;
  int     n_taken = 0;
  int     n_errors = 0;
  int     quiet_cycles = 0;

  rgb_to_hsv_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .opacity    (opacity)
  );

  always #5 clk = ~clk;

  // Hue rounds half up toward +inf, also for a negative sector offset.
  function automatic hsv_t rgb_to_hsv_expected(pixel_t p);
    hsv_t res;
    int mx;
    int mn;
    int chroma;
    int diff;
    int num;
    int den;
    int h;
    logic [1:0] sector;
    mx = p.r;
    mn = p.r;
    if (p.g > mx) mx = p.g;
    if (p.b > mx) mx = p.b;
    if (p.g < mn) mn = p.g;
    if (p.b < mn) mn = p.b;
    chroma = mx - mn;
    res.val = mx[PixW-1:0];
    res.opac = p.a;
    if (chroma == 0) begin
      res.hue = '0;
      res.sat = '0;
    end else begin
      if (mx == p.r) begin
        sector = SEC_RED;
        diff = int'(p.g) - int'(p.b);
      end else if (mx == p.g) begin
        sector = SEC_GREEN;
        diff = int'(p.b) - int'(p.r);
      end else begin
        sector = SEC_BLUE;
        diff = int'(p.r) - int'(p.g);
      end
      num = 2 * HueStep * diff + chroma;
      den = 2 * chroma;
      h = 2 * int'(sector) * HueStep + ((num >= 0) ? num / den : -((-num + den - 1) / den));
      if (h < 0) h += HueCircle;
      if (h >= HueCircle) h -= HueCircle;
      res.hue = h[HueW-1:0];
      res.sat = SatW'((chroma * 2 * SatScale + mx) / (2 * mx));
    end
    return res;
  endfunction

  function automatic pixel_t pick_pixel();
    pixel_t p;
    logic [PixW-1:0] edge_vals [4];
    int mode;
    edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255};
    p = pixel_t'($urandom);
    mode = $urandom_range(9);
    case (mode)
      0: begin
        p.g = p.r;
        p.b = p.r;
      end
      1: p.g = p.r;
      2: p.b = p.r;
      3: p.b = p.g;
      4: begin
        p.r = edge_vals[$urandom_range(3)];
        p.g = edge_vals[$urandom_range(3)];
        p.b = edge_vals[$urandom_range(3)];
      end
      5: begin
        // near-grey pixels: tiny chroma stresses hue rounding
        p.g = p.r + PixW'($urandom_range(2)) - 8'd1;
        p.b = p.r + PixW'($urandom_range(2)) - 8'd1;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_errors < MaxPrints)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // Driver: hold a pixel until it is taken, then advance or idle.
  always @(posedge clk) begin : drive
    pixel_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pixel_q.pop_front();
        red <= nxt.r;
        green <= nxt.g;
        blue <= nxt.b;
        alpha <= nxt.a;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted transaction, compare on every strobe.
  always @(posedge clk) begin : watch
    hsv_t want;
    if (!rst) begin
      if (start && !busy) begin
        hsv_expected_q.push_back(rgb_to_hsv_expected({red, green, blue, alpha}));
        n_taken++;
      end
      if (done) begin
        if (hsv_expected_q.size() == 0) begin
          report_mismatch("unexpected result, hue", hue, 0);
        end else begin
          want = hsv_expected_q.pop_front();
          if (hue !== want.hue) report_mismatch("hue", hue, want.hue);
          if (saturation !== want.sat) report_mismatch("saturation", saturation, want.sat);
          if (brightness !== want.val) report_mismatch("brightness", brightness, want.val);
          if (opacity !== want.opac) report_mismatch("opacity", opacity, want.opac);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g,
                             logic [PixW-1:0] b, logic [PixW-1:0] a);
    pixel_q.push_back({r, g, b, a});
    n_queued++;
  endtask

  task automatic drain();
    while (n_taken != n_queued || hsv_expected_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int idle_phases [4];
    idle_phases = '{0, 73, 0, 27};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0, 8'd0, 8'h55);
    queue_pixel(8'd0, 8'd255, 8'd0, 8'hAA);
    queue_pixel(8'd0, 8'd0, 8'd255, 8'd1);
    queue_pixel(8'd255, 8'd0, 8'd1, 8'd254);
    queue_pixel(8'd255, 8'd0, 8'd255, 8'd128);
    queue_pixel(8'd255, 8'd255, 8'd0, 8'd127);
    queue_pixel(8'd0, 8'd255, 8'd255, 8'd0);
    queue_pixel(8'd1, 8'd0, 8'd0, 8'd255);
    queue_pixel(8'd1, 8'd1, 8'd0, 8'd3);
    queue_pixel(8'd0, 8'd1, 8'd2, 8'd4);
    queue_pixel(8'd255, 8'd128, 8'd0, 8'd8);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd16);
    queue_pixel(8'd10, 8'd5, 8'd0, 8'd32);
    queue_pixel(8'd128, 8'd127, 8'd127, 8'd64);
    queue_pixel(8'd254, 8'd255, 8'd253, 8'd170);
    queue_pixel(8'd3, 8'd2, 8'd4, 8'd85);
    queue_pixel(8'd1, 8'd255, 8'd254, 8'd200);
    queue_pixel(8'd254, 8'd1, 8'd255, 8'd100);
    drain();

    foreach (idle_phases[ph]) begin
      idle_pct = idle_phases[ph];
      repeat (PerPhase) begin
        pixel_q.push_back(pick_pixel());
        n_queued++;
      end
      drain();
    end

    repeat (TailWait) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
